>>> rtl/ffa_pkg.sv
`default_nettype none
package ffa_pkg;

    // fixed field widths
    localparam int SIZE_W = 12;
    localparam int ADDR_W = 12;
    localparam int HEAP_W = 13;
    localparam int STAT_W = 2;
    localparam int WIDE_W = 14;
    localparam int ENTRY_W = 2 * ADDR_W;

    // heap length in units, tied to the address width above
    localparam int HEAP_UNITS = 4096;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_FIT  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_PAST    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd3;

    // request kinds
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // datapath micro-operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_CFG,
        OP_LOAD,
        OP_INIT,
        OP_DISP,
        OP_RD_K,
        OP_A_CHK,
        OP_A_TAKE,
        OP_REM_RD,
        OP_REM_WR,
        OP_REM_END,
        OP_F_CHK,
        OP_SH_INIT,
        OP_SH_RD,
        OP_SH_WR,
        OP_INS,
        OP_J_RDA,
        OP_J_RDB,
        OP_J_CHK,
        OP_J_SEC,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic is_free;
        logic cnt_zero;
        logic bad_free;
        logic fit;
        logic k_more;
        logic ge;
        logic k_gt_p;
        logic split;
        logic j_more;
        logic adj;
        logic p_nz;
        logic out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

>>> rtl/ffa_ram.sv
`default_nettype none
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

>>> rtl/ffa_ctrl.sv
`default_nettype none
module ffa_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire ffa_pkg::dp_stat_t  stat,
    output ffa_pkg::dp_cmd_t        cmd
);

    typedef enum logic [23:0] {
        ST_IDLE    = 24'h000001,
        ST_INIT    = 24'h000002,
        ST_DISP    = 24'h000004,
        ST_A_RD    = 24'h000008,
        ST_A_CHK   = 24'h000010,
        ST_A_TAKE  = 24'h000020,
        ST_REM_CHK = 24'h000040,
        ST_REM_RD  = 24'h000080,
        ST_REM_WR  = 24'h000100,
        ST_REM_END = 24'h000200,
        ST_F_RD    = 24'h000400,
        ST_F_CHK   = 24'h000800,
        ST_SH_INIT = 24'h001000,
        ST_SH_CHK  = 24'h002000,
        ST_SH_RD   = 24'h004000,
        ST_SH_WR   = 24'h008000,
        ST_INS     = 24'h010000,
        ST_J_CHK0  = 24'h020000,
        ST_J_RDA   = 24'h040000,
        ST_J_RDB   = 24'h080000,
        ST_J_CHK   = 24'h100000,
        ST_J_END   = 24'h200000,
        ST_J_SEC   = 24'h400000,
        ST_DONE    = 24'h800000
    } state_t;

    state_t state_reg, state_next;
    logic   ret_join_reg, ret_join_next;
    logic   phase_reg, phase_next;

    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_tready  = (state_reg == ST_IDLE) && !cfg_valid;

    // sequencer
    always_comb begin
        state_next    = state_reg;
        ret_join_next = ret_join_reg;
        phase_next    = phase_reg;
        cmd.op        = ffa_pkg::OP_NONE;
        case (state_reg)
            ST_IDLE: begin
                if (cfg_valid) begin
                    cmd.op     = ffa_pkg::OP_CFG;
                    state_next = ST_INIT;
                end else if (s_tvalid) begin
                    cmd.op     = ffa_pkg::OP_LOAD;
                    state_next = ST_DISP;
                end
            end
            ST_INIT: begin
                cmd.op     = ffa_pkg::OP_INIT;
                state_next = ST_IDLE;
            end
            ST_DISP: begin
                cmd.op = ffa_pkg::OP_DISP;
                if (!stat.is_free) begin
                    state_next = stat.cnt_zero ? ST_DONE : ST_A_RD;
                end else if (stat.bad_free) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = stat.cnt_zero ? ST_SH_INIT : ST_F_RD;
                end
            end
            ST_A_RD: begin
                cmd.op     = ffa_pkg::OP_RD_K;
                state_next = ST_A_CHK;
            end
            ST_A_CHK: begin
                cmd.op = ffa_pkg::OP_A_CHK;
                if (stat.fit) begin
                    state_next = ST_A_TAKE;
                end else if (!stat.k_more) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_A_RD;
                end
            end
            ST_A_TAKE: begin
                cmd.op        = ffa_pkg::OP_A_TAKE;
                ret_join_next = 1'b0;
                state_next    = stat.split ? ST_DONE : ST_REM_CHK;
            end
            ST_REM_CHK: begin
                state_next = stat.k_more ? ST_REM_RD : ST_REM_END;
            end
            ST_REM_RD: begin
                cmd.op     = ffa_pkg::OP_REM_RD;
                state_next = ST_REM_WR;
            end
            ST_REM_WR: begin
                cmd.op     = ffa_pkg::OP_REM_WR;
                state_next = ST_REM_CHK;
            end
            ST_REM_END: begin
                cmd.op     = ffa_pkg::OP_REM_END;
                state_next = ret_join_reg ? ST_J_END : ST_DONE;
            end
            ST_F_RD: begin
                cmd.op     = ffa_pkg::OP_RD_K;
                state_next = ST_F_CHK;
            end
            ST_F_CHK: begin
                cmd.op     = ffa_pkg::OP_F_CHK;
                state_next = (stat.ge || !stat.k_more) ? ST_SH_INIT : ST_F_RD;
            end
            ST_SH_INIT: begin
                cmd.op     = ffa_pkg::OP_SH_INIT;
                state_next = ST_SH_CHK;
            end
            ST_SH_CHK: begin
                state_next = stat.k_gt_p ? ST_SH_RD : ST_INS;
            end
            ST_SH_RD: begin
                cmd.op     = ffa_pkg::OP_SH_RD;
                state_next = ST_SH_WR;
            end
            ST_SH_WR: begin
                cmd.op     = ffa_pkg::OP_SH_WR;
                state_next = ST_SH_CHK;
            end
            ST_INS: begin
                cmd.op     = ffa_pkg::OP_INS;
                phase_next = 1'b0;
                state_next = ST_J_CHK0;
            end
            ST_J_CHK0: begin
                state_next = stat.j_more ? ST_J_RDA : ST_J_END;
            end
            ST_J_RDA: begin
                cmd.op     = ffa_pkg::OP_J_RDA;
                state_next = ST_J_RDB;
            end
            ST_J_RDB: begin
                cmd.op     = ffa_pkg::OP_J_RDB;
                state_next = ST_J_CHK;
            end
            ST_J_CHK: begin
                cmd.op        = ffa_pkg::OP_J_CHK;
                ret_join_next = 1'b1;
                state_next    = stat.adj ? ST_REM_CHK : ST_J_END;
            end
            ST_J_END: begin
                state_next = (!phase_reg && stat.p_nz) ? ST_J_SEC : ST_DONE;
            end
            ST_J_SEC: begin
                cmd.op     = ffa_pkg::OP_J_SEC;
                phase_next = 1'b1;
                state_next = ST_J_CHK0;
            end
            ST_DONE: begin
                cmd.op = ffa_pkg::OP_OUT;
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            ret_join_reg <= 1'b0;
            phase_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ret_join_reg <= ret_join_next;
            phase_reg    <= phase_next;
        end
    end

    // a register write always re-initialises the table next
    a_cfg_init: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready |=> state_reg == ST_INIT)
        else $error("config write not followed by table init");

    // an accepted word leaves idle
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == ST_DISP)
        else $error("accepted word not dispatched");

    // the join that returns from a removal only runs for frees
    a_ret: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_REM_END && ret_join_reg |-> stat.is_free)
        else $error("join return on an allocate");

endmodule
`default_nettype wire

>>> rtl/ffa_dp.sv
`default_nettype none
module ffa_dp #(
    parameter int MAX_FREE_SEGMENTS = 64,
    parameter int HEADER_UNITS      = 1
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire ffa_pkg::dp_cmd_t               cmd,
    output ffa_pkg::dp_stat_t                   stat,
    input  wire logic                           s_tuser,
    input  wire logic [23:0]                    s_tdata,
    input  wire logic [ffa_pkg::HEAP_W-1:0]     cfg_data,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [15:0]                         m_tdata
);

    localparam int IDX_W = $clog2(MAX_FREE_SEGMENTS);
    localparam int CNT_W = $clog2(MAX_FREE_SEGMENTS + 1);
    localparam int SA_W  = $clog2(ffa_pkg::HEAP_UNITS);
    localparam int AW    = ffa_pkg::ADDR_W;
    localparam int WW    = ffa_pkg::WIDE_W;
    localparam int HW    = ffa_pkg::HEAP_W;

    logic [HW-1:0]              heap_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [IDX_W-1:0]           k_reg, p_reg, j_reg;
    logic                       act_reg;
    logic [AW-1:0]              size_reg, addr_reg;
    logic [AW-1:0]              cur_start_reg, cur_len_reg;
    logic [ffa_pkg::STAT_W-1:0] status_reg;
    logic [AW-1:0]              payload_reg;
    logic                       out_valid_reg;
    logic [15:0]                out_data_reg;

    logic [HW-1:0]                 lim, cap;
    logic [AW-1:0]                 blk, t_start, t_len, s_rdata, rem;
    logic                          addr_ok;
    logic [WW-1:0]                 ns, sum, cur_end;
    logic                          t_we, t_re, s_we;
    logic [IDX_W-1:0]              t_waddr, t_raddr;
    logic [ffa_pkg::ENTRY_W-1:0]   t_wdata, t_rdata;
    logic [SA_W-1:0]               s_waddr;
    logic [AW-1:0]                 s_wdata;
    logic [AW-1:0]                 in_blk;

    // clamp of the heap length in use
    always_comb begin
        if (heap_reg < HW'(HEADER_UNITS + 1)) begin
            lim = HW'(HEADER_UNITS + 1);
        end else if (32'(heap_reg) > ffa_pkg::HEAP_UNITS) begin
            lim = HW'(ffa_pkg::HEAP_UNITS);
        end else begin
            lim = heap_reg;
        end
    end
    assign cap = lim - HW'(HEADER_UNITS);

    assign t_start = t_rdata[ffa_pkg::ENTRY_W-1:AW];
    assign t_len   = t_rdata[AW-1:0];
    assign blk     = addr_reg - AW'(HEADER_UNITS);
    assign in_blk  = s_tdata[23:12] - AW'(HEADER_UNITS);
    assign addr_ok = (addr_reg >= AW'(HEADER_UNITS)) && (HW'(blk) < lim);
    assign rem     = cur_len_reg - size_reg;
    assign ns      = WW'(cur_start_reg) + WW'(HEADER_UNITS) + WW'(size_reg);
    assign cur_end = WW'(cur_start_reg) + WW'(HEADER_UNITS) + WW'(cur_len_reg);

    // merged length, saturated at the heap capacity
    always_comb begin
        sum = WW'(cur_len_reg) + WW'(HEADER_UNITS) + WW'(t_len);
        if (sum > WW'(cap)) begin
            sum = WW'(cap);
        end
    end

    // flags to the sequencer
    always_comb begin
        stat.is_free  = (act_reg == ffa_pkg::ACT_FREE);
        stat.cnt_zero = (cnt_reg == '0);
        stat.bad_free = !addr_ok || (cnt_reg >= CNT_W'(MAX_FREE_SEGMENTS));
        stat.fit      = (t_len >= size_reg);
        stat.k_more   = (CNT_W'(k_reg) + CNT_W'(1)) < cnt_reg;
        stat.ge       = (t_start >= blk);
        stat.k_gt_p   = (k_reg > p_reg);
        stat.split    = (rem >= AW'(HEADER_UNITS + 1));
        stat.j_more   = (CNT_W'(j_reg) + CNT_W'(1)) < cnt_reg;
        stat.adj      = (cur_end == WW'(t_start));
        stat.p_nz     = (p_reg != '0);
        stat.out_free = !out_valid_reg || m_tready;
    end

    // memory port control
    always_comb begin
        t_we    = 1'b0;
        t_waddr = k_reg;
        t_wdata = t_rdata;
        t_re    = 1'b0;
        t_raddr = k_reg;
        s_we    = 1'b0;
        s_waddr = SA_W'(cur_start_reg);
        s_wdata = size_reg;
        case (cmd.op)
            ffa_pkg::OP_INIT: begin
                t_we    = 1'b1;
                t_waddr = '0;
                t_wdata = {AW'(0), AW'(cap)};
            end
            ffa_pkg::OP_RD_K: begin
                t_re = 1'b1;
            end
            ffa_pkg::OP_A_TAKE: begin
                if (stat.split) begin
                    if (ns < WW'(lim)) begin
                        t_we    = 1'b1;
                        t_wdata = {ns[AW-1:0], rem - AW'(HEADER_UNITS)};
                        s_we    = 1'b1;
                    end
                end else begin
                    s_we    = 1'b1;
                    s_wdata = cur_len_reg;
                end
            end
            ffa_pkg::OP_REM_RD: begin
                t_re    = 1'b1;
                t_raddr = k_reg + IDX_W'(1);
            end
            ffa_pkg::OP_REM_WR,
            ffa_pkg::OP_SH_WR: begin
                t_we = 1'b1;
            end
            ffa_pkg::OP_SH_RD: begin
                t_re    = 1'b1;
                t_raddr = k_reg - IDX_W'(1);
            end
            ffa_pkg::OP_INS: begin
                t_we    = 1'b1;
                t_waddr = p_reg;
                t_wdata = {blk, s_rdata};
            end
            ffa_pkg::OP_J_RDA: begin
                t_re    = 1'b1;
                t_raddr = j_reg;
            end
            ffa_pkg::OP_J_RDB: begin
                t_re    = 1'b1;
                t_raddr = j_reg + IDX_W'(1);
            end
            ffa_pkg::OP_J_CHK: begin
                if (stat.adj) begin
                    t_we    = 1'b1;
                    t_waddr = j_reg;
                    t_wdata = {cur_start_reg, sum[AW-1:0]};
                end
            end
            default: begin
            end
        endcase
    end

    // free segment table: {start, length}
    ffa_ram #(.WIDTH(ffa_pkg::ENTRY_W), .DEPTH(MAX_FREE_SEGMENTS)) u_tbl (
        .aclk  (aclk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .re    (t_re),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    // block header store, read once per request at load
    ffa_ram #(.WIDTH(AW), .DEPTH(ffa_pkg::HEAP_UNITS)) u_hdr (
        .aclk  (aclk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .re    (cmd.op == ffa_pkg::OP_LOAD),
        .raddr (SA_W'(in_blk)),
        .rdata (s_rdata)
    );

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_reg      <= HW'(ffa_pkg::HEAP_UNITS);
            cnt_reg       <= CNT_W'(1);
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.op == ffa_pkg::OP_CFG) begin
                heap_reg <= cfg_data;
            end
            case (cmd.op)
                ffa_pkg::OP_INIT:    cnt_reg <= CNT_W'(1);
                ffa_pkg::OP_REM_END: cnt_reg <= cnt_reg - CNT_W'(1);
                ffa_pkg::OP_INS:     cnt_reg <= cnt_reg + CNT_W'(1);
                default: begin
                end
            endcase
            if (cmd.op == ffa_pkg::OP_OUT && stat.out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tvalid && m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            ffa_pkg::OP_LOAD: begin
                act_reg     <= s_tuser;
                size_reg    <= s_tdata[11:0];
                addr_reg    <= s_tdata[23:12];
                k_reg       <= '0;
                status_reg  <= ffa_pkg::STAT_OK;
                payload_reg <= '0;
            end
            ffa_pkg::OP_DISP: begin
                if (act_reg == ffa_pkg::ACT_ALLOC && cnt_reg == '0) begin
                    status_reg <= ffa_pkg::STAT_NO_FIT;
                end else if (act_reg == ffa_pkg::ACT_FREE && addr_ok
                             && cnt_reg >= CNT_W'(MAX_FREE_SEGMENTS)) begin
                    status_reg <= ffa_pkg::STAT_FULL;
                end
            end
            ffa_pkg::OP_A_CHK: begin
                cur_start_reg <= t_start;
                cur_len_reg   <= t_len;
                if (!stat.fit) begin
                    k_reg <= k_reg + IDX_W'(1);
                    if (!stat.k_more) begin
                        status_reg <= ffa_pkg::STAT_NO_FIT;
                    end
                end
            end
            ffa_pkg::OP_A_TAKE: begin
                if (stat.split && ns >= WW'(lim)) begin
                    status_reg <= ffa_pkg::STAT_PAST;
                end else begin
                    payload_reg <= cur_start_reg + AW'(HEADER_UNITS);
                end
            end
            ffa_pkg::OP_REM_WR: begin
                k_reg <= k_reg + IDX_W'(1);
            end
            ffa_pkg::OP_F_CHK: begin
                if (!stat.ge) begin
                    k_reg <= k_reg + IDX_W'(1);
                end
            end
            ffa_pkg::OP_SH_INIT: begin
                p_reg <= k_reg;
                k_reg <= IDX_W'(cnt_reg);
            end
            ffa_pkg::OP_SH_WR: begin
                k_reg <= k_reg - IDX_W'(1);
            end
            ffa_pkg::OP_INS: begin
                j_reg <= p_reg;
            end
            ffa_pkg::OP_J_RDB: begin
                cur_start_reg <= t_start;
                cur_len_reg   <= t_len;
            end
            ffa_pkg::OP_J_CHK: begin
                k_reg <= j_reg + IDX_W'(1);
            end
            ffa_pkg::OP_J_SEC: begin
                j_reg <= p_reg - IDX_W'(1);
            end
            ffa_pkg::OP_OUT: begin
                if (stat.out_free) begin
                    out_data_reg <= {2'b00, payload_reg, status_reg};
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // table never holds more than its capacity
    a_cnt_max: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_FREE_SEGMENTS))
        else $error("free table count overflow");

    // an insert adds exactly one entry
    a_ins: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == ffa_pkg::OP_INS |=> cnt_reg == $past(cnt_reg) + CNT_W'(1))
        else $error("insert did not grow the table");

    // a result issued into a free register is presented next cycle
    a_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == ffa_pkg::OP_OUT && stat.out_free |=> m_tvalid)
        else $error("result lost");

endmodule
`default_nettype wire

>>> rtl/first_fit_block_allocator.sv
// First-fit heap allocator with neighbour coalescing.
// Input channel s_*: one word per request; s_tuser is the action (0 allocate,
// 1 free), s_tdata carries size_units and block_address. Result channel m_*:
// one word per request carrying status and payload_address.
// cfg_*: writes heap_size and re-initialises the free table to one segment.
// Requests are served one at a time by a sequencer walking the free table
// memory, one entry at a time on the search, reading then checking each.
// An allocate takes the first segment that fits; when a whole segment is
// taken, each entry above it is shifted down. A free costs a search, a
// shift of the entries above the insert point and up to two joins.
// After reset the table is initialised (heap_size 4096) before the first
// request is taken. The result sits in an output register; the next request
// is accepted while it waits, but its own result holds the sequencer until
// the receiver takes the earlier one.
`default_nettype none
module first_fit_block_allocator #(
    parameter int MAX_FREE_SEGMENTS = 64,
    parameter int HEADER_UNITS      = 1
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [23:0]                s_tdata,   // size_units, block_address
    input  wire logic                       s_tuser,   // action
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [15:0]                     m_tdata,   // status, payload_address, pad
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [ffa_pkg::HEAP_W-1:0] cfg_data   // heap_size
);

    ffa_pkg::dp_cmd_t  cmd;
    ffa_pkg::dp_stat_t stat;

    ffa_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ffa_dp #(
        .MAX_FREE_SEGMENTS (MAX_FREE_SEGMENTS),
        .HEADER_UNITS      (HEADER_UNITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .cfg_data (cfg_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire
